>>> rtl/core/lfm_pkg.sv
package lfm_pkg;

    // number of monitored LEDs and bits per sensor sample
    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 12;

    localparam int SAMPLES_W   = 24;
    localparam int TICK_W      = 24;
    localparam int THR_W       = 12;
    localparam int CNT_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // packed sample word widened so every lane has a slice (upper lanes read zero)
    localparam int SAMPLE_SPAN = CHANNELS * SAMPLE_BITS;
    localparam int SAMPLE_PAD_W = (SAMPLE_SPAN > SAMPLES_W) ? SAMPLE_SPAN : SAMPLES_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFF_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ABOVE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FLUCTUATIONS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRESS_TICKS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_TICKS      = 3'd5;

    // reset values
    localparam logic [THR_W-1:0]  RST_THRESHOLD    = 12'd1000;
    localparam logic [CNT_W-1:0]  RST_MAX_COUNT    = 8'd5;
    localparam logic [TICK_W-1:0] RST_STRESS_TICKS = 24'd14400000;
    localparam logic [TICK_W-1:0] RST_CHECK_TICKS  = 24'd2000;

    // phase and request codes
    localparam logic PHASE_STRESS = 1'b0;
    localparam logic PHASE_CHECK  = 1'b1;
    localparam logic REQ_TICK     = 1'b0;
    localparam logic REQ_BUTTON   = 1'b1;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_REL  = 2'd1,
        FAULT_NREL = 2'd2
    } t_fault;

    // what one lane reports to the merge stage for the current item
    typedef struct packed {
        logic new_rel;
        logic new_nrel;
        logic failed;
    } t_lane_flags;

endpackage

>>> rtl/core/lfm_lane.sv
module lfm_lane
    import lfm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_phase,
    input  logic [THR_W-1:0]       i_thr,
    input  logic [CNT_W-1:0]       i_max_above,
    input  logic [CNT_W-1:0]       i_max_fluct,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output t_lane_flags            o_flags
);

    logic [CNT_W-1:0] r_above, n_above;
    logic [CNT_W-1:0] r_drop,  n_drop;
    t_fault           r_fault, n_fault;
    logic             rel, nrel;

    always_comb begin
        n_above = r_above;
        n_drop  = r_drop;
        n_fault = r_fault;
        rel     = 1'b0;
        nrel    = 1'b0;
        if (i_en && (r_fault == FAULT_NONE)) begin
            if (THR_W'(i_sample) > i_thr) begin
                n_above = (r_above == CNT_MAX) ? r_above : r_above + 1'b1;
                if (n_above > i_max_above) begin
                    n_fault = FAULT_REL;
                    rel     = 1'b1;
                end
            end else if ((i_phase == PHASE_CHECK) && (r_above != '0)) begin
                n_drop  = (r_drop == CNT_MAX) ? r_drop : r_drop + 1'b1;
                n_above = '0;
            end
            if ((i_phase == PHASE_CHECK) && (n_drop > i_max_fluct)) begin
                n_fault = FAULT_NREL;
                nrel    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above <= '0;
            r_drop  <= '0;
            r_fault <= FAULT_NONE;
        end else begin
            r_above <= n_above;
            r_drop  <= n_drop;
            r_fault <= n_fault;
        end
    end

    assign o_flags.new_rel  = rel;
    assign o_flags.new_nrel = nrel;
    assign o_flags.failed   = (n_fault != FAULT_NONE);

endmodule

>>> rtl/core/led_life_test_fault_monitor.sv
// LED life-test fault monitor.
// Input channel (i_valid / o_stall): each item is either a sample tick carrying
// packed sensor samples (channel 0 in the low bits) or a phase button press.
// An item is taken at a clock edge with i_valid high and o_stall low.
// Output channel (o_valid / i_stall): exactly one result item per input item,
// reporting phase, the faults declared by this item, the bypass mask, the
// all-failed flag, the running flag and whether the phase limit is reached.
// The result is registered: it appears in the output register the cycle
// after the input item is taken. Throughput is one item per cycle while the
// output is not stalled; the lanes and the tick counter update in the
// accepting cycle, so the next item may follow straight away.
// When the receiver stalls, the result register holds and o_stall rises only
// while that register is full and stalled, so no item is lost.
// The user makes configuration writes (i_cfg_valid / o_cfg_ready, always ready)
// while the block is idle (not enforced here); unknown indexes are ignored.
// Reset (synchronous, active low) restores the default registers, empties the
// result register, clears all counters and faults, and starts in the check
// phase with sampling enabled.
module led_life_test_fault_monitor
    import lfm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_req_type,
    input  logic [SAMPLES_W-1:0]  i_samples,
    // result output
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_phase,
    output logic [CHANNELS-1:0]   o_new_relevant,
    output logic [CHANNELS-1:0]   o_new_nonrelevant,
    output logic [CHANNELS-1:0]   o_bypass_mask,
    output logic                  o_all_failed,
    output logic                  o_running,
    output logic                  o_phase_done,
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [THR_W-1:0]  r_off_thr, r_check_thr;
    logic [CNT_W-1:0]  r_max_above, r_max_fluct;
    logic [TICK_W-1:0] r_stress_ticks, r_check_ticks;

    // control state
    logic [TICK_W-1:0] r_tick, n_tick;
    logic              r_phase, n_phase;
    logic              r_running, n_running;

    // result register
    logic              r_valid;
    logic              r_res_phase, r_res_all, r_res_running, r_res_done;
    logic [CHANNELS-1:0] r_res_rel, r_res_nrel, r_res_mask;

    logic in_acc, out_acc, tick_item, btn_item, at_limit, do_sample;
    logic [TICK_W-1:0] limit, n_limit;
    logic [THR_W-1:0]  thr;
    logic [SAMPLE_PAD_W-1:0] samples_wide;
    t_lane_flags       lane_flags [CHANNELS];
    logic [CHANNELS-1:0] new_rel, new_nrel, failed;
    logic all_failed;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_valid & i_stall;
    assign in_acc      = i_valid & ~o_stall;
    assign out_acc     = r_valid & ~i_stall;

    assign tick_item = in_acc & (i_req_type == REQ_TICK);
    assign btn_item  = in_acc & (i_req_type == REQ_BUTTON);
    assign limit     = (r_phase == PHASE_CHECK) ? r_check_ticks : r_stress_ticks;
    assign at_limit  = (r_tick >= limit);
    assign do_sample = tick_item & r_running & ~at_limit;
    assign thr       = (r_phase == PHASE_CHECK) ? r_check_thr : r_off_thr;

    assign samples_wide = SAMPLE_PAD_W'(i_samples);

    // one lane per LED
    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        lfm_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (do_sample),
            .i_phase     (r_phase),
            .i_thr       (thr),
            .i_max_above (r_max_above),
            .i_max_fluct (r_max_fluct),
            .i_sample    (samples_wide[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .o_flags     (lane_flags[g])
        );
        assign new_rel[g]  = lane_flags[g].new_rel;
        assign new_nrel[g] = lane_flags[g].new_nrel;
        assign failed[g]   = lane_flags[g].failed;
    end

    // merge: lane findings steer the shared run control
    assign all_failed = &failed;

    always_comb begin
        n_tick    = r_tick;
        n_phase   = r_phase;
        n_running = r_running;
        if (btn_item) begin
            if (at_limit) begin
                n_phase = ~r_phase;
                n_tick  = '0;
            end
            n_running = 1'b1;
        end else if (tick_item && r_running) begin
            if (!at_limit) begin
                n_tick = r_tick + 1'b1;
                if ((new_rel | new_nrel) != '0) begin
                    n_running = 1'b0;
                end
            end else begin
                n_running = 1'b0;
            end
            if (all_failed) begin
                n_running = 1'b0;
            end
        end
    end

    assign n_limit = (n_phase == PHASE_CHECK) ? r_check_ticks : r_stress_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_thr      <= RST_THRESHOLD;
            r_check_thr    <= RST_THRESHOLD;
            r_max_above    <= RST_MAX_COUNT;
            r_max_fluct    <= RST_MAX_COUNT;
            r_stress_ticks <= RST_STRESS_TICKS;
            r_check_ticks  <= RST_CHECK_TICKS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_OFF_THRESHOLD:    r_off_thr      <= i_cfg_data[THR_W-1:0];
                REG_CHECK_THRESHOLD:  r_check_thr    <= i_cfg_data[THR_W-1:0];
                REG_MAX_ABOVE:        r_max_above    <= i_cfg_data[CNT_W-1:0];
                REG_MAX_FLUCTUATIONS: r_max_fluct    <= i_cfg_data[CNT_W-1:0];
                REG_STRESS_TICKS:     r_stress_ticks <= i_cfg_data[TICK_W-1:0];
                REG_CHECK_TICKS:      r_check_ticks  <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_phase   <= PHASE_CHECK;
            r_running <= 1'b1;
            r_valid   <= 1'b0;
        end else begin
            r_tick    <= n_tick;
            r_phase   <= n_phase;
            r_running <= n_running;
            if (in_acc) begin
                r_valid <= 1'b1;
            end else if (out_acc) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only when an item is taken
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res_phase   <= n_phase;
            r_res_rel     <= new_rel;
            r_res_nrel    <= new_nrel;
            r_res_mask    <= failed;
            r_res_all     <= all_failed;
            r_res_running <= n_running;
            r_res_done    <= (n_tick >= n_limit);
        end
    end

    assign o_valid           = r_valid;
    assign o_phase           = r_res_phase;
    assign o_new_relevant    = r_res_rel;
    assign o_new_nonrelevant = r_res_nrel;
    assign o_bypass_mask     = r_res_mask;
    assign o_all_failed      = r_res_all;
    assign o_running         = r_res_running;
    assign o_phase_done      = r_res_done;

endmodule
